### src/ttcw_pkg.sv
// ----------------------------------------------------------------------------
// Text terminal character writer package
// Request and result types, control and status bundles, and character codes.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam int         TAB_STEP    = 8;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [7:0] read_col;
  } ttcw_in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cursor_col;
    logic [5:0] cursor_row;
  } ttcw_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
    logic sweep_all;
  } ttcw_cmd_t;

  typedef struct packed {
    logic scroll;
    logic row_end;
    logic grid_end;
  } ttcw_sts_t;

endpackage

### src/ttcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text terminal character writer controller
// Sequences the power-up clearing pass, request execution, row clearing on
// scroll and the result strobe.
// ----------------------------------------------------------------------------
module ttcw_ctrl import ttcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ttcw_sts_t sts,
  output logic      busy,
  output logic      out_valid,
  output ttcw_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy      = !((state_r == S_IDLE) || (state_r == S_RESP));
  assign out_valid = (state_r == S_RESP);
  assign accept    = start && !busy;

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.exec      = (state_r == S_EXEC);
    cmd.sweep     = (state_r == S_INIT) || (state_r == S_SCROLL);
    cmd.sweep_all = (state_r == S_INIT);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sts.grid_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = sts.scroll ? S_SCROLL : S_RESP;
      end
      S_SCROLL: begin
        if (sts.row_end) state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/ttcw_dp.sv
// ----------------------------------------------------------------------------
// Text terminal character writer datapath
// Cell memory addressed as a ring of rows, cursor logic and clearing counters.
// ----------------------------------------------------------------------------
module ttcw_dp import ttcw_pkg::*; #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ttcw_cmd_t cmd,
  input  ttcw_in_t  in_req,
  output ttcw_sts_t sts,
  output ttcw_out_t out_res
);

  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int DEPTH = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [RW:0]   ROWS_X   = (RW+1)'(SCREEN_ROWS);
  localparam logic [CW:0]   COLS_X   = (CW+1)'(SCREEN_COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

  logic [7:0]    mem [DEPTH];

  ttcw_in_t      req_r;
  logic [RW-1:0] prow_r;
  logic          rd_ok_r;
  logic [7:0]    rdata_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [RW-1:0] top_r;
  logic [RW-1:0] clr_row_r;
  logic [CW-1:0] cnt_r;

  logic [RW-1:0] base_row;
  logic [RW:0]   row_sum;
  logic [RW-1:0] prow_nxt;
  logic          in_range;

  logic          is_put;
  logic          printable;
  logic [CW:0]   col_ext;
  logic [CW:0]   tab_col;
  logic [CW:0]   inc_col;
  logic          wrap;
  logic          adv;
  logic          scroll;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  logic [RW-1:0] row_sel;
  logic [CW-1:0] col_sel;
  logic [AW-1:0] addr;
  logic          we;
  logic          re;
  logic [7:0]    wdata;

  always_comb begin
    base_row = (in_req.func == FUNC_READ) ? in_req.read_row[RW-1:0] : row_r;
    row_sum  = {1'b0, top_r} + {1'b0, base_row};
    prow_nxt = (row_sum >= ROWS_X) ? RW'(row_sum - ROWS_X) : row_sum[RW-1:0];
    in_range = ({1'b0, in_req.read_row} < 7'(SCREEN_ROWS)) &&
               ({1'b0, in_req.read_col} < 9'(SCREEN_COLS));
  end

  always_comb begin
    is_put    = (req_r.func == FUNC_PUT);
    printable = (req_r.char_code >= CH_SPACE) && (req_r.char_code <= CH_PRINT_HI);
    col_ext   = {1'b0, col_r};
    tab_col   = (col_ext + (CW+1)'(TAB_STEP)) & ~((CW+1)'(TAB_STEP - 1));
    inc_col   = col_ext + (CW+1)'(1);
    col_nxt   = col_r;
    row_nxt   = row_r;
    wrap      = 1'b0;
    adv       = 1'b0;
    scroll    = 1'b0;
    priority if (req_r.char_code == CH_LF) begin
      adv = 1'b1;
    end else if (req_r.char_code == CH_CR) begin
      col_nxt = '0;
    end else if (req_r.char_code == CH_TAB) begin
      if (tab_col >= COLS_X) wrap = 1'b1;
      else col_nxt = tab_col[CW-1:0];
    end else if (req_r.char_code == CH_BS) begin
      if (col_r != '0) col_nxt = col_r - CW'(1);
    end else if (printable) begin
      if (inc_col >= COLS_X) wrap = 1'b1;
      else col_nxt = inc_col[CW-1:0];
    end
    if (wrap) begin
      col_nxt = '0;
      adv     = 1'b1;
    end
    if (adv) begin
      if (row_r == LAST_ROW) scroll = 1'b1;
      else row_nxt = row_r + RW'(1);
    end
  end

  always_comb begin
    row_sel = cmd.sweep ? clr_row_r : prow_r;
    if (cmd.sweep) col_sel = cnt_r;
    else if (is_put) col_sel = col_r;
    else col_sel = req_r.read_col[CW-1:0];
    addr  = AW'(row_sel) * AW'(SCREEN_COLS) + AW'(col_sel);
    we    = cmd.sweep || (cmd.exec && is_put && printable);
    re    = cmd.exec && rd_ok_r;
    wdata = cmd.sweep ? CH_SPACE : req_r.char_code;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req;
      prow_r <= prow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r   <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      top_r     <= '0;
      clr_row_r <= '0;
      cnt_r     <= '0;
    end else begin
      if (cmd.load) begin
        rd_ok_r <= (in_req.func == FUNC_READ) && in_range;
      end
      if (cmd.exec && is_put) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (scroll) begin
          top_r     <= (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
          clr_row_r <= top_r;
          cnt_r     <= '0;
        end
      end
      if (cmd.sweep) begin
        if (cnt_r == LAST_COL) begin
          cnt_r <= '0;
          if (cmd.sweep_all) clr_row_r <= clr_row_r + RW'(1);
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  always_comb begin
    sts          = '0;
    sts.scroll   = is_put && scroll;
    sts.row_end  = (cnt_r == LAST_COL);
    sts.grid_end = (cnt_r == LAST_COL) && (clr_row_r == LAST_ROW);
  end

  always_comb begin
    out_res            = '0;
    out_res.cell_char  = rd_ok_r ? rdata_r : CH_SPACE;
    out_res.cursor_col = 8'(col_r);
    out_res.cursor_row = 6'(row_r);
  end

endmodule

### src/text_terminal_char_writer_core.sv
// Sequence: an accepted request is loaded, executed and its result strobed; a
// request that scrolls the grid first clears the new bottom row.
// Flow: a new request is taken when idle or while the last result strobes; a
// scroll clears the new bottom row through the single memory write port,
// one cell per cycle. Reset: the cursor homes and a clearing pass writes
// spaces to all SCREEN_ROWS*SCREEN_COLS cells with busy held high.
// ----------------------------------------------------------------------------
// Text terminal character writer core
// Character-cell grid with cursor, control-character handling and scrolling.
// ----------------------------------------------------------------------------
module text_terminal_char_writer_core import ttcw_pkg::*; #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ttcw_in_t  in_req,
  output logic      out_valid,
  output ttcw_out_t out_res
);

  ttcw_cmd_t cmd;
  ttcw_sts_t sts;

  ttcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ttcw_dp #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .sts     (sts),
    .out_res (out_res)
  );

endmodule

### src/ttcw_chk.sv
// ----------------------------------------------------------------------------
// Text terminal character writer port checker
// Checks request and result sequencing and cursor bounds at the ports.
// ----------------------------------------------------------------------------
module ttcw_chk import ttcw_pkg::*; #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input ttcw_out_t out_res
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("request not followed by a busy cycle");

  a_idle_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy high while a result is shown");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((9'(out_res.cursor_col) < 9'(SCREEN_COLS)) &&
                   (7'(out_res.cursor_row) < 7'(SCREEN_ROWS))))
    else $error("cursor reported outside the grid");

endmodule

bind text_terminal_char_writer_core ttcw_chk #(
  .SCREEN_ROWS (SCREEN_ROWS),
  .SCREEN_COLS (SCREEN_COLS)
) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

### tb/sv/text_terminal_char_writer_core_test.sv
// ----------------------------------------------------------------------------
// Text terminal character writer core testbench
// Sends put and read requests through the start/busy handshake, with random
// idle gaps and stretches without any. It keeps its own copy of the character
// grid and cursor, and checks every strobed result against that copy in order.
// ----------------------------------------------------------------------------
module text_terminal_char_writer_core_test import ttcw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int REQ_TARGET = 400;
  localparam int MAX_IDLE = 18;
  localparam int DRAIN_CYCLES = 2 * COLS + 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_HIGH_FIRST = 8'h80;
  localparam logic [7:0] CH_HIGH_LAST = 8'hFF;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_UNIT_SEP = 8'h1F;

  typedef struct {
    ttcw_in_t    req;
    int unsigned idle;
  } req_slot_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  ttcw_in_t  in_req = '0;
  logic      out_valid;
  ttcw_out_t out_res;

  req_slot_t   pending_reqs[$];
  req_slot_t   head_slot;
  ttcw_out_t   cell_cursor_q[$];
  ttcw_out_t   due_res;
  logic [7:0]  screen[ROWS][COLS];
  int unsigned cursor_col_m;
  int unsigned cursor_row_m;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned req_count = 0;
  bit          quiet = 1'b0;

  text_terminal_char_writer_core #(
    .SCREEN_ROWS(ROWS),
    .SCREEN_COLS(COLS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void clear_terminal();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        screen[r][c] = CH_SPACE;
      end
    end
    cursor_col_m = 0;
    cursor_row_m = 0;
  endfunction

  function automatic void line_down();
    cursor_row_m++;
    if (cursor_row_m >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++) begin
        for (int c = 0; c < COLS; c++) begin
          screen[r][c] = screen[r + 1][c];
        end
      end
      for (int c = 0; c < COLS; c++) begin
        screen[ROWS - 1][c] = CH_SPACE;
      end
      cursor_row_m = ROWS - 1;
    end
  endfunction

  function automatic void wrap_column();
    if (cursor_col_m >= COLS) begin
      cursor_col_m = 0;
      line_down();
    end
  endfunction

  function automatic ttcw_out_t emulate_request(ttcw_in_t req);
    ttcw_out_t res;
    res.cell_char = CH_SPACE;
    if (req.func == FUNC_PUT) begin
      case (req.char_code)
        CH_LF: line_down();
        CH_CR: cursor_col_m = 0;
        CH_TAB: begin
          cursor_col_m = (cursor_col_m + TAB_STEP) & ~(TAB_STEP - 1);
          wrap_column();
        end
        CH_BS: begin
          if (cursor_col_m > 0) cursor_col_m--;
        end
        default: begin
          if (req.char_code >= CH_SPACE && req.char_code <= CH_PRINT_HI) begin
            screen[cursor_row_m][cursor_col_m] = req.char_code;
            cursor_col_m++;
            wrap_column();
          end
        end
      endcase
    end else if (req.read_row < ROWS && req.read_col < COLS) begin
      res.cell_char = screen[req.read_row][req.read_col];
    end
    res.cursor_col = cursor_col_m[7:0];
    res.cursor_row = cursor_row_m[5:0];
    return res;
  endfunction

  function automatic int unsigned draw_idle();
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic void push_put(logic [7:0] code);
    req_slot_t slot;
    slot.req.func = FUNC_PUT;
    slot.req.char_code = code;
    slot.req.read_row = 6'($urandom);
    slot.req.read_col = 8'($urandom);
    slot.idle = draw_idle();
    pending_reqs.push_back(slot);
    if (code == CH_LF || code == CH_CR || code == CH_TAB || code == CH_BS ||
        (code >= CH_SPACE && code <= CH_PRINT_HI)) begin
      req_count++;
    end
  endfunction

  function automatic void push_read(int unsigned row, int unsigned col);
    req_slot_t slot;
    slot.req.func = FUNC_READ;
    slot.req.char_code = 8'($urandom);
    slot.req.read_row = 6'(row);
    slot.req.read_col = 8'(col);
    slot.idle = draw_idle();
    pending_reqs.push_back(slot);
    req_count++;
  endfunction

  function automatic logic [7:0] noise_code();
    logic [7:0] code;
    do begin
      code = 8'($urandom);
    end while ((code >= CH_SPACE && code <= CH_PRINT_HI) || code == CH_LF ||
               code == CH_CR || code == CH_TAB || code == CH_BS);
    return code;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned expected_val,
                                 input int unsigned got_val);
    $display("MISMATCH at cycle %0d: %s, expected 0x%0h, got 0x%0h",
             cycle_count, what, expected_val, got_val);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
      clear_terminal();
    end else begin
      if (start && !busy) begin
        cell_cursor_q.push_back(emulate_request(in_req));
      end
      if (!start || !busy) begin
        if (pending_reqs.size() == 0) begin
          start <= 1'b0;
        end else begin
          head_slot = pending_reqs.pop_front();
          if (head_slot.idle != 0) begin
            head_slot.idle = head_slot.idle - 1;
            pending_reqs.push_front(head_slot);
            start <= 1'b0;
          end else begin
            in_req <= head_slot.req;
            start <= 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cell_cursor_q.size() == 0) begin
        report_mismatch("result with no request outstanding", 0, 32'(out_res));
      end else begin
        due_res = cell_cursor_q.pop_front();
        if (out_res.cell_char !== due_res.cell_char) begin
          report_mismatch("cell_char", 32'(due_res.cell_char), 32'(out_res.cell_char));
        end
        if (out_res.cursor_col !== due_res.cursor_col) begin
          report_mismatch("cursor_col", 32'(due_res.cursor_col),
                          32'(out_res.cursor_col));
        end
        if (out_res.cursor_row !== due_res.cursor_row) begin
          report_mismatch("cursor_row", 32'(due_res.cursor_row),
                          32'(out_res.cursor_row));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int unsigned kind;

    push_read(0, 0);
    push_read(ROWS - 1, COLS - 1);
    push_read(ROWS, 0);
    push_read(0, COLS);
    push_read(63, 255);
    push_put(CH_SPACE);
    push_put(CH_PRINT_HI);
    push_read(0, 1);
    push_put(CH_CR);
    push_put(CH_BS);
    push_put(CH_BS);
    push_put(CH_NUL);
    push_put(CH_UNIT_SEP);
    push_put(CH_DEL);
    push_put(CH_HIGH_FIRST);
    push_put(CH_HIGH_LAST);
    push_put(CH_TAB);
    push_put(CH_TAB);
    push_put(8'h41);
    push_put(CH_CR);
    push_put(CH_LF);
    push_read(0, 16);

    while (req_count < REQ_TARGET) begin
      quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          len = $urandom_range(1, 40);
          repeat (len) push_put(8'($urandom_range(CH_SPACE, CH_PRINT_HI)));
          if ($urandom_range(0, 1) == 1) begin
            push_put(CH_CR);
            push_put(CH_LF);
          end
        end
        4: begin
          len = $urandom_range(1, 6);
          repeat (len) push_put(CH_LF);
        end
        5: begin
          len = $urandom_range(1, 12);
          repeat (len) push_put(CH_TAB);
          push_put(8'($urandom_range(CH_SPACE, CH_PRINT_HI)));
        end
        6: begin
          len = $urandom_range(1, 10);
          repeat (len) push_put(CH_BS);
          push_put(8'($urandom_range(CH_SPACE, CH_PRINT_HI)));
        end
        7: begin
          len = $urandom_range(1, 8);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
              push_read($urandom_range(0, 63), $urandom_range(0, 255));
            end else if ($urandom_range(0, 1) == 0) begin
              push_read($urandom_range(0, ROWS - 1), $urandom_range(0, 39));
            end else begin
              push_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
            end
          end
        end
        8: begin
          len = $urandom_range(1, 4);
          repeat (len) push_put(noise_code());
        end
        default: begin
          push_put(CH_CR);
          push_put(CH_LF);
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || start || cell_cursor_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
src/ttcw_pkg.sv
src/ttcw_ctrl.sv
src/ttcw_dp.sv
src/text_terminal_char_writer_core.sv
src/ttcw_chk.sv
tb/sv/text_terminal_char_writer_core_test.sv
